// ----- design/sample_covariance_correlation_macros.svh -----
// assertion macros for the covariance and correlation top design file
`ifndef SAMPLE_COVARIANCE_CORRELATION_MACROS_SVH
`define SAMPLE_COVARIANCE_CORRELATION_MACROS_SVH
`ifndef SYNTHESIS
`define SCC_ASSERT_SAME(lbl, ck, rn, ante, cons) \
  lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
    else $error("scc assertion failed");
`define SCC_ASSERT_NEXT(lbl, ck, rn, ante, cons) \
  lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
    else $error("scc assertion failed");
`else
`define SCC_ASSERT_SAME(lbl, ck, rn, ante, cons)
`define SCC_ASSERT_NEXT(lbl, ck, rn, ante, cons)
`endif
`endif

// ----- design/scc_pkg.sv -----
// widths, constants and status codes of the covariance and correlation block
package scc_pkg;
  localparam int SAMPLE_BITS = 16;
  localparam int MAX_SAMPLES = 65536;
  localparam int CNT_W       = $clog2(MAX_SAMPLES + 1);
  localparam int SUM_W       = SAMPLE_BITS + CNT_W;
  localparam int SQ_W        = 2 * SAMPLE_BITS + CNT_W - 2;
  localparam int VAL_W       = 64;
  localparam int MUL_W       = 33;
  localparam int PROD_W      = 2 * MUL_W;
  localparam int ACC_W       = 128;
  localparam int NUM_W       = 128;
  localparam int DEN_W       = 64;
  localparam int ROOT_W      = 64;
  localparam int FRAC_COR    = 30;
  localparam int FRAC_COV    = 16;

  typedef enum logic [1:0] {
    STAT_OK   = 2'd0,
    STAT_FEW  = 2'd1,
    STAT_FLAT = 2'd2
  } stat_t;
endpackage

// ----- design/scc_in_if.sv -----
// sample pair channel
interface scc_in_if;
  logic                                     valid;
  logic                                     ready;
  logic signed [scc_pkg::SAMPLE_BITS-1:0]   x_sample;
  logic signed [scc_pkg::SAMPLE_BITS-1:0]   y_sample;
  logic                                     last_sample;
  modport source (output valid, x_sample, y_sample, last_sample, input ready);
  modport sink (input valid, x_sample, y_sample, last_sample, output ready);
endinterface

// ----- design/scc_out_if.sv -----
// result channel
interface scc_out_if;
  logic                               valid;
  logic                               ready;
  logic signed [scc_pkg::VAL_W-1:0]   stat_value;
  logic [1:0]                         stat_status;
  modport source (output valid, stat_value, stat_status, input ready);
  modport sink (input valid, stat_value, stat_status, output ready);
endinterface

// ----- design/scc_mul.sv -----
// shared registered signed multiplier
module scc_mul (
  input  logic                               clk,
  input  logic signed [scc_pkg::MUL_W-1:0]   mul_a,
  input  logic signed [scc_pkg::MUL_W-1:0]   mul_b,
  output logic signed [scc_pkg::PROD_W-1:0]  prod_r
);
  import scc_pkg::*;

  // one product per cycle
  always_ff @(posedge clk) begin
    prod_r <= PROD_W'(mul_a) * PROD_W'(mul_b);
  end
endmodule

// ----- design/scc_sqrt.sv -----
// bit-serial integer square root, two radicand bits per cycle
module scc_sqrt (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             start,
  input  logic [scc_pkg::ACC_W-1:0]        radicand,
  output logic                             done,
  output logic [scc_pkg::ROOT_W-1:0]       root
);
  import scc_pkg::*;

  localparam int REM_W = ROOT_W + 4;

  logic [ACC_W-1:0]  rad_r;
  logic [REM_W-1:0]  rem_r;
  logic [ROOT_W-1:0] root_r;
  logic [$clog2(ROOT_W)-1:0] cnt_r;
  logic              busy_r;
  logic              done_r;
  logic [REM_W-1:0]  rem_sh;
  logic [REM_W-1:0]  trial;
  logic              ge;

  // trial subtract of the next digit
  always_comb begin
    rem_sh = {rem_r[REM_W-3:0], rad_r[ACC_W-1:ACC_W-2]};
    trial  = {2'b00, root_r, 2'b01};
    ge     = rem_sh >= trial;
  end

  // control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '1;
      end else if (busy_r) begin
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == '0) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    if (start) begin
      rad_r  <= radicand;
      rem_r  <= '0;
      root_r <= '0;
    end else if (busy_r) begin
      rad_r  <= {rad_r[ACC_W-3:0], 2'b00};
      rem_r  <= ge ? rem_sh - trial : rem_sh;
      root_r <= {root_r[ROOT_W-2:0], ge};
    end
  end

  assign done = done_r;
  assign root = root_r;
endmodule

// ----- design/scc_div.sv -----
// restoring divider, one quotient bit per cycle
module scc_div (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            start,
  input  logic [scc_pkg::NUM_W-1:0]       num,
  input  logic [scc_pkg::DEN_W-1:0]       den,
  output logic                            done,
  output logic [scc_pkg::VAL_W-1:0]       quo
);
  import scc_pkg::*;

  logic [NUM_W-1:0]  num_r;
  logic [DEN_W-1:0]  den_r;
  logic [DEN_W-1:0]  rem_r;
  logic [VAL_W-1:0]  quo_r;
  logic [$clog2(NUM_W)-1:0] cnt_r;
  logic              busy_r;
  logic              done_r;
  logic [DEN_W:0]    rem_sh;
  logic [DEN_W:0]    diff;
  logic              ge;

  // trial subtract
  always_comb begin
    rem_sh = {rem_r, num_r[NUM_W-1]};
    diff   = rem_sh - {1'b0, den_r};
    ge     = rem_sh >= {1'b0, den_r};
  end

  // control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '1;
      end else if (busy_r) begin
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == '0) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    if (start) begin
      num_r <= num;
      den_r <= den;
      rem_r <= '0;
      quo_r <= '0;
    end else if (busy_r) begin
      num_r <= {num_r[NUM_W-2:0], 1'b0};
      rem_r <= ge ? diff[DEN_W-1:0] : rem_sh[DEN_W-1:0];
      quo_r <= {quo_r[VAL_W-2:0], ge};
    end
  end

  assign done = done_r;
  assign quo  = quo_r;
endmodule

// ----- design/sample_covariance_correlation.sv -----
// Covariance / Pearson correlation top: each sample pair is an accept step plus 4 MAC steps.
// A last pair adds wide-product sequencing on the shared multiplier, then covariance goes
// through the bit-serial divider; correlation adds the normalize shifts, the square root and
// the divider, then the result register, reached at once for under two samples or flat correlation.
// Synchronous active-low reset clears the sums, the mode register and the output valid.
`include "sample_covariance_correlation_macros.svh"
module sample_covariance_correlation (
  input  logic       clk,
  input  logic       rst_n,
  scc_in_if.sink     in_ch,
  scc_out_if.source  out_ch,
  input  logic       cfg_wr_en,
  input  logic       cfg_wr_data
);
  import scc_pkg::*;

  typedef enum logic [6:0] {
    S_IDLE = 7'b0000001,
    S_ACC  = 7'b0000010,
    S_FIN  = 7'b0000100,
    S_NORM = 7'b0001000,
    S_ROOT = 7'b0010000,
    S_DIV  = 7'b0100000,
    S_OUT  = 7'b1000000
  } state_t;

  typedef enum logic [2:0] {
    D_NONE, D_SXX, D_SYY, D_SXY, D_DEN, D_PRD
  } dest_t;

  typedef struct packed {
    logic       valid;
    logic       first;
    logic       sub;
    logic [1:0] shift;
    dest_t      dest;
  } mac_ctl_t;

  localparam logic [3:0] ACC_LAST = 4'd3;
  localparam logic [3:0] FIN_LAST = 4'd15;
  localparam logic [VAL_W-1:0] COR_ONE = VAL_W'(1) << FRAC_COR;

  state_t state_r, state_nxt;
  logic [3:0] step_r, step_nxt;
  logic       mode_r;
  logic signed [SAMPLE_BITS-1:0] xs_r, ys_r;
  logic       last_r, acc_en_r;
  logic [CNT_W-1:0] cnt_r;
  logic signed [SUM_W-1:0] sx_r, sy_r;
  logic [SQ_W-1:0] sxx_sum_r, syy_sum_r;
  logic signed [SQ_W:0] sxy_sum_r;
  logic [VAL_W-1:0] sxx_r, syy_r, sxy_r, den_r;
  logic [ACC_W-1:0] acc_r, prd_r, mnum_r;
  logic       neg_r;
  logic [VAL_W-1:0] res_value_r;
  stat_t      res_status_r;
  logic       out_valid_r;
  logic [VAL_W-1:0] out_value_r;
  stat_t      out_status_r;
  mac_ctl_t   ctl_r, ctl_nxt;

  logic signed [MUL_W-1:0] mul_a, mul_b;
  logic signed [PROD_W-1:0] prod_r;
  logic signed [MUL_W-1:0] n_op, x_op, y_op;
  logic [ACC_W-1:0] prod_ext, prod_sh, acc_base, acc_nxt;
  logic [VAL_W-1:0] mag, q_lim;
  logic [NUM_W-1:0] div_num;
  logic [DEN_W-1:0] div_den;
  logic       sqrt_start, div_start, sq_done, dv_done;
  logic [ROOT_W-1:0] sq_root;
  logic [VAL_W-1:0] dv_quo;
  logic       out_load, few, flat;

  // shared units
  scc_mul u_mul (.clk(clk), .mul_a(mul_a), .mul_b(mul_b), .prod_r(prod_r));

  scc_sqrt u_sqrt (
    .clk(clk), .rst_n(rst_n), .start(sqrt_start), .radicand(prd_r),
    .done(sq_done), .root(sq_root)
  );

  scc_div u_div (
    .clk(clk), .rst_n(rst_n), .start(div_start), .num(div_num), .den(div_den),
    .done(dv_done), .quo(dv_quo)
  );

  // operand forms
  always_comb begin
    n_op = $signed({{(MUL_W-CNT_W){1'b0}}, cnt_r});
    x_op = $signed({{(MUL_W-SAMPLE_BITS){xs_r[SAMPLE_BITS-1]}}, xs_r});
    y_op = $signed({{(MUL_W-SAMPLE_BITS){ys_r[SAMPLE_BITS-1]}}, ys_r});
    mag  = sxy_r[VAL_W-1] ? VAL_W'(0) - sxy_r : sxy_r;
    few  = cnt_r < CNT_W'(2);
    flat = (sxx_r == '0) || (syy_r == '0);
  end

  // multiplier schedule
  always_comb begin
    mul_a   = '0;
    mul_b   = '0;
    ctl_nxt = '0;
    ctl_nxt.dest = D_NONE;
    case (state_r)
      S_ACC: begin
        case (step_r)
          4'd0: begin mul_a = x_op; mul_b = x_op; end
          4'd1: begin mul_a = y_op; mul_b = y_op; end
          4'd2: begin mul_a = x_op; mul_b = y_op; end
          default: ;
        endcase
      end
      S_FIN: begin
        ctl_nxt.valid = step_r < 4'd14;
        case (step_r)
          4'd0, 4'd3: begin
            mul_a = n_op;
            mul_b = $signed({1'b0, (step_r == 4'd0) ? sxx_sum_r[31:0] : syy_sum_r[31:0]});
            ctl_nxt.first = 1'b1;
          end
          4'd1, 4'd4: begin
            mul_a = n_op;
            mul_b = $signed({{(MUL_W-(SQ_W-32)){1'b0}},
                             (step_r == 4'd1) ? sxx_sum_r[SQ_W-1:32] : syy_sum_r[SQ_W-1:32]});
            ctl_nxt.shift = 2'd1;
          end
          4'd2: begin
            mul_a = sx_r; mul_b = sx_r; ctl_nxt.sub = 1'b1; ctl_nxt.dest = D_SXX;
          end
          4'd5: begin
            mul_a = sy_r; mul_b = sy_r; ctl_nxt.sub = 1'b1; ctl_nxt.dest = D_SYY;
          end
          4'd6: begin
            mul_a = n_op; mul_b = $signed({1'b0, sxy_sum_r[31:0]}); ctl_nxt.first = 1'b1;
          end
          4'd7: begin
            mul_a = n_op;
            mul_b = $signed({{(MUL_W-(SQ_W+1-32)){sxy_sum_r[SQ_W]}}, sxy_sum_r[SQ_W:32]});
            ctl_nxt.shift = 2'd1;
          end
          4'd8: begin
            mul_a = sx_r; mul_b = sy_r; ctl_nxt.sub = 1'b1; ctl_nxt.dest = D_SXY;
          end
          4'd9: begin
            mul_a = n_op; mul_b = n_op - MUL_W'(1);
            ctl_nxt.first = 1'b1; ctl_nxt.dest = D_DEN;
          end
          4'd10: begin
            mul_a = $signed({1'b0, sxx_r[31:0]}); mul_b = $signed({1'b0, syy_r[31:0]});
            ctl_nxt.first = 1'b1;
          end
          4'd11: begin
            mul_a = $signed({1'b0, sxx_r[31:0]}); mul_b = $signed({1'b0, syy_r[63:32]});
            ctl_nxt.shift = 2'd1;
          end
          4'd12: begin
            mul_a = $signed({1'b0, sxx_r[63:32]}); mul_b = $signed({1'b0, syy_r[31:0]});
            ctl_nxt.shift = 2'd1;
          end
          4'd13: begin
            mul_a = $signed({1'b0, sxx_r[63:32]}); mul_b = $signed({1'b0, syy_r[63:32]});
            ctl_nxt.shift = 2'd2; ctl_nxt.dest = D_PRD;
          end
          default: ;
        endcase
      end
      default: ;
    endcase
  end

  // wide accumulate of shifted partial products
  always_comb begin
    prod_ext = {{(ACC_W-PROD_W){prod_r[PROD_W-1]}}, prod_r};
    case (ctl_r.shift)
      2'd1:    prod_sh = prod_ext << 32;
      2'd2:    prod_sh = prod_ext << 64;
      default: prod_sh = prod_ext;
    endcase
    acc_base = ctl_r.first ? '0 : acc_r;
    acc_nxt  = ctl_r.sub ? acc_base - prod_sh : acc_base + prod_sh;
  end

  // divider operands and result limit
  always_comb begin
    if (state_r == S_ROOT) begin
      div_num = mnum_r + {{(NUM_W-ROOT_W+1){1'b0}}, sq_root[ROOT_W-1:1]};
      div_den = sq_root;
    end else begin
      div_num = {{(NUM_W-VAL_W-FRAC_COV){1'b0}}, mag, {FRAC_COV{1'b0}}}
              + {{(NUM_W-DEN_W+1){1'b0}}, den_r[DEN_W-1:1]};
      div_den = den_r;
    end
    q_lim = (!mode_r && (dv_quo > COR_ONE)) ? COR_ONE : dv_quo;
  end

  assign out_load = (state_r == S_OUT) && (!out_valid_r || out_ch.ready);

  // sequencer
  always_comb begin
    state_nxt  = state_r;
    step_nxt   = step_r;
    sqrt_start = 1'b0;
    div_start  = 1'b0;
    case (state_r)
      S_IDLE: begin
        if (in_ch.valid) begin
          state_nxt = S_ACC;
          step_nxt  = '0;
        end
      end
      S_ACC: begin
        if (step_r == ACC_LAST) begin
          step_nxt  = '0;
          state_nxt = last_r ? S_FIN : S_IDLE;
        end else begin
          step_nxt = step_r + 4'd1;
        end
      end
      S_FIN: begin
        if (step_r == FIN_LAST) begin
          step_nxt = '0;
          if (few) begin
            state_nxt = S_OUT;
          end else if (mode_r) begin
            div_start = 1'b1;
            state_nxt = S_DIV;
          end else if (flat) begin
            state_nxt = S_OUT;
          end else begin
            state_nxt = S_NORM;
          end
        end else begin
          step_nxt = step_r + 4'd1;
        end
      end
      S_NORM: begin
        if (prd_r[ACC_W-1:ACC_W-4] != '0) begin
          sqrt_start = 1'b1;
          state_nxt  = S_ROOT;
        end
      end
      S_ROOT: begin
        if (sq_done) begin
          div_start = 1'b1;
          state_nxt = S_DIV;
        end
      end
      S_DIV: begin
        if (dv_done) state_nxt = S_OUT;
      end
      S_OUT: begin
        if (out_load) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // control state, sums and output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      step_r      <= '0;
      mode_r      <= 1'b0;
      cnt_r       <= '0;
      sx_r        <= '0;
      sy_r        <= '0;
      sxx_sum_r   <= '0;
      syy_sum_r   <= '0;
      sxy_sum_r   <= '0;
      ctl_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      step_r  <= step_nxt;
      ctl_r   <= ctl_nxt;
      if (cfg_wr_en) mode_r <= cfg_wr_data;

      // per-sample accumulation
      if (state_r == S_ACC && acc_en_r) begin
        case (step_r)
          4'd0: begin
            cnt_r <= cnt_r + CNT_W'(1);
            sx_r  <= sx_r + {{(SUM_W-SAMPLE_BITS){xs_r[SAMPLE_BITS-1]}}, xs_r};
            sy_r  <= sy_r + {{(SUM_W-SAMPLE_BITS){ys_r[SAMPLE_BITS-1]}}, ys_r};
          end
          4'd1: sxx_sum_r <= sxx_sum_r + prod_r[SQ_W-1:0];
          4'd2: syy_sum_r <= syy_sum_r + prod_r[SQ_W-1:0];
          4'd3: sxy_sum_r <= sxy_sum_r + prod_r[SQ_W:0];
          default: ;
        endcase
      end

      // result transaction
      out_valid_r <= out_load || (out_valid_r && !out_ch.ready);
      if (out_load) begin
        cnt_r       <= '0;
        sx_r        <= '0;
        sy_r        <= '0;
        sxx_sum_r   <= '0;
        syy_sum_r   <= '0;
        sxy_sum_r   <= '0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    // input transaction
    if (state_r == S_IDLE && in_ch.valid) begin
      xs_r     <= in_ch.x_sample;
      ys_r     <= in_ch.y_sample;
      last_r   <= in_ch.last_sample;
      acc_en_r <= cnt_r < CNT_W'(MAX_SAMPLES);
    end

    // wide accumulator and its destinations
    if (ctl_r.valid) begin
      acc_r <= acc_nxt;
      case (ctl_r.dest)
        D_SXX:   sxx_r <= acc_nxt[VAL_W-1:0];
        D_SYY:   syy_r <= acc_nxt[VAL_W-1:0];
        D_SXY:   sxy_r <= acc_nxt[VAL_W-1:0];
        D_DEN:   den_r <= acc_nxt[DEN_W-1:0];
        D_PRD:   prd_r <= acc_nxt;
        default: ;
      endcase
    end

    // special cases and normalize setup
    if (state_r == S_FIN && step_r == FIN_LAST) begin
      neg_r       <= sxy_r[VAL_W-1];
      res_value_r <= '0;
      mnum_r      <= {{(NUM_W-VAL_W-FRAC_COR){1'b0}}, mag, {FRAC_COR{1'b0}}};
      if (few) res_status_r <= STAT_FEW;
      else if (!mode_r && flat) res_status_r <= STAT_FLAT;
      else res_status_r <= STAT_OK;
    end

    // even normalize shift, numerator follows by half
    if (state_r == S_NORM && prd_r[ACC_W-1:ACC_W-4] == '0) begin
      prd_r  <= {prd_r[ACC_W-3:0], 2'b00};
      mnum_r <= {mnum_r[NUM_W-2:0], 1'b0};
    end

    if (state_r == S_DIV && dv_done) begin
      res_value_r <= neg_r ? VAL_W'(0) - q_lim : q_lim;
    end

    if (out_load) begin
      out_value_r  <= res_value_r;
      out_status_r <= res_status_r;
    end
  end

  assign in_ch.ready        = state_r == S_IDLE;
  assign out_ch.valid       = out_valid_r;
  assign out_ch.stat_value  = out_value_r;
  assign out_ch.stat_status = out_status_r;

  `SCC_ASSERT_SAME(a_cnt_bound, clk, rst_n, 1'b1, cnt_r <= CNT_W'(MAX_SAMPLES))
  `SCC_ASSERT_NEXT(a_clear_after_result, clk, rst_n, out_load, (cnt_r == '0) && (sx_r == '0) && out_valid_r)
  `SCC_ASSERT_SAME(a_flag_zero_value, clk, rst_n, out_valid_r && (out_status_r != STAT_OK), out_value_r == '0)
endmodule
